// ===== design/dual_encoder_period_capture_defines.svh =====
// Assertion macros for the dual encoder period capture block.
// Used by dual_encoder_period_capture.sv; expects clk and rst in scope.
`ifndef DUAL_ENCODER_PERIOD_CAPTURE_DEFINES_SVH
`define DUAL_ENCODER_PERIOD_CAPTURE_DEFINES_SVH

// Checked at every edge once reset is released.
`define DECAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DECAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/decap_pkg.sv =====
// Types and constants for the dual encoder period capture block.
// No dependencies; imported by dual_encoder_period_capture.
`default_nettype none

package decap_pkg;

  localparam int unsigned CountW      = 16;
  localparam int unsigned StampW      = 8;
  localparam int unsigned PrescaleW   = 2;
  localparam int unsigned PrescaleDiv = 2;
  localparam logic [CountW-1:0] LimitReset = 16'd255;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PINS = 1'b1
  } opcode_t;

  // Input beat payload, lowest field last.
  typedef struct packed {
    logic              tick_pending;
    logic [StampW-1:0] timer_value;
    logic              enc_b;
    logic              enc_a;
  } in_item_t;

  // Result beat payload, lowest field last.
  typedef struct packed {
    logic [CountW-1:0] ticks_between_b;
    logic [StampW-1:0] stamp_prev_b;
    logic [StampW-1:0] stamp_now_b;
    logic [CountW-1:0] ticks_between_a;
    logic [StampW-1:0] stamp_prev_a;
    logic [StampW-1:0] stamp_now_a;
    logic              capture_b;
    logic              capture_a;
    logic              half_rate_tick;
    logic              timeout_b;
    logic              timeout_a;
    logic              tick_flag;
  } out_item_t;

  localparam int unsigned OutItemW = $bits(out_item_t);
  localparam int unsigned InItemW  = $bits(in_item_t);

endpackage

`default_nettype wire

// ===== design/dual_encoder_period_capture.sv =====
// Dual wheel encoder period capture: tick counters, prescaler and edge stamps.
// Depends on decap_pkg and dual_encoder_period_capture_defines.svh.
//
// One beat per clock is taken while the block does not stall, and one result
// beat leaves for every input beat, through the input register, then the result
// register. The rate is set by the per-wheel counter update, which runs
// combinationally between the input register and the result register. Results
// back up into the input register when m_axis_tready is low; the block stalls
// only once both registers are full. timeout_limit is written on the cfg
// channel, which is always ready.
`default_nettype none
`include "dual_encoder_period_capture_defines.svh"

module dual_encoder_period_capture #(
  parameter int unsigned PRESCALE_DIV = decap_pkg::PrescaleDiv
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [decap_pkg::CountW-1:0]   cfg_data,     // timeout_limit
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // enc_a[0], enc_b[1], timer_value[9:2], tick_pending[10], zero[15:11]
  input  wire logic [decap_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                           s_axis_tuser, // opcode
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tick_flag[0], timeout_a[1], timeout_b[2], half_rate_tick[3], capture_a[4],
  // capture_b[5], stamp_now_a[13:6], stamp_prev_a[21:14],
  // ticks_between_a[37:22], stamp_now_b[45:38], stamp_prev_b[53:46],
  // ticks_between_b[69:54], zero[71:70]
  output logic [decap_pkg::OutDataW-1:0]      m_axis_tdata
);

  import decap_pkg::*;

  // Configuration
  logic [CountW-1:0] timeout_limit;

  // Input register
  logic     in_valid;
  opcode_t  in_op;
  in_item_t in_item;

  // Block state
  logic                 last_a;
  logic                 last_b;
  logic [CountW-1:0]    cnt_a;
  logic [CountW-1:0]    cnt_b;
  logic [PrescaleW-1:0] prescale;
  logic [StampW-1:0]    now_a;
  logic [StampW-1:0]    prev_a;
  logic [StampW-1:0]    now_b;
  logic [StampW-1:0]    prev_b;
  logic [CountW-1:0]    latched_a;
  logic [CountW-1:0]    latched_b;

  // Next values
  logic [CountW-1:0]    cnt_a_next;
  logic [CountW-1:0]    cnt_b_next;
  logic [PrescaleW-1:0] prescale_next;
  out_item_t            res_next;

  // Result register
  logic      out_valid;
  out_item_t res;

  logic advance;
  logic rise_a;
  logic rise_b;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OutDataW - OutItemW)'(0), res};

  assign rise_a = (in_op == OP_PINS) && in_item.enc_a && !last_a;
  assign rise_b = (in_op == OP_PINS) && in_item.enc_b && !last_b;

  always_comb begin
    logic                 do_tick;
    logic [CountW-1:0]    inc_a;
    logic [CountW-1:0]    inc_b;
    logic [PrescaleW-1:0] inc_p;
    logic [CountW-1:0]    tck_a;
    logic [CountW-1:0]    tck_b;
    logic [PrescaleW-1:0] tck_p;

    do_tick = (in_op == OP_TICK) || (in_item.tick_pending && (rise_a || rise_b));
    inc_a   = cnt_a + CountW'(1);
    inc_b   = cnt_b + CountW'(1);
    inc_p   = prescale + PrescaleW'(1);

    res_next = '0;
    tck_a    = cnt_a;
    tck_b    = cnt_b;
    tck_p    = prescale;

    // One tick step at most; it runs ahead of either capture.
    if (do_tick) begin
      res_next.tick_flag = 1'b1;
      tck_a = inc_a;
      tck_b = inc_b;
      tck_p = inc_p;
      if (inc_a > timeout_limit) begin
        res_next.timeout_a = 1'b1;
        tck_a = '0;
      end
      if (inc_b > timeout_limit) begin
        res_next.timeout_b = 1'b1;
        tck_b = '0;
      end
      if (inc_p >= PrescaleW'(PRESCALE_DIV)) begin
        res_next.half_rate_tick = 1'b1;
        tck_p = '0;
      end
    end

    cnt_a_next    = tck_a;
    cnt_b_next    = tck_b;
    prescale_next = tck_p;

    res_next.stamp_now_a     = now_a;
    res_next.stamp_prev_a    = prev_a;
    res_next.ticks_between_a = latched_a;
    res_next.stamp_now_b     = now_b;
    res_next.stamp_prev_b    = prev_b;
    res_next.ticks_between_b = latched_b;

    if (rise_a) begin
      res_next.capture_a       = 1'b1;
      res_next.stamp_prev_a    = now_a;
      res_next.stamp_now_a     = in_item.timer_value;
      res_next.ticks_between_a = tck_a;
      cnt_a_next               = '0;
    end
    if (rise_b) begin
      res_next.capture_b       = 1'b1;
      res_next.stamp_prev_b    = now_b;
      res_next.stamp_now_b     = in_item.timer_value;
      res_next.ticks_between_b = tck_b;
      cnt_b_next               = '0;
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= LimitReset;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      last_a        <= 1'b0;
      last_b        <= 1'b0;
      cnt_a         <= '0;
      cnt_b         <= '0;
      prescale      <= '0;
      now_a         <= '0;
      prev_a        <= '0;
      now_b         <= '0;
      prev_b        <= '0;
      latched_a     <= '0;
      latched_b     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_limit <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        cnt_a     <= cnt_a_next;
        cnt_b     <= cnt_b_next;
        prescale  <= prescale_next;
        now_a     <= res_next.stamp_now_a;
        prev_a    <= res_next.stamp_prev_a;
        now_b     <= res_next.stamp_now_b;
        prev_b    <= res_next.stamp_prev_b;
        latched_a <= res_next.ticks_between_a;
        latched_b <= res_next.ticks_between_b;
        if (in_op == OP_PINS) begin
          last_a <= in_item.enc_a;
          last_b <= in_item.enc_b;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= opcode_t'(s_axis_tuser);
      in_item <= in_item_t'(s_axis_tdata[InItemW-1:0]);
    end
    if (advance) begin
      res <= res_next;
    end
  end

  `DECAP_ASSERT(a_capture_clears_a, advance && rise_a |=> cnt_a == '0,
    "wheel A counter not cleared after capture")
  `DECAP_ASSERT(a_capture_clears_b, advance && rise_b |=> cnt_b == '0,
    "wheel B counter not cleared after capture")
  `DECAP_ASSERT(a_timeout_needs_tick,
    advance && (res_next.timeout_a || res_next.timeout_b || res_next.half_rate_tick)
    |-> res_next.tick_flag,
    "timeout or half-rate flag without a tick step")
  `DECAP_ASSERT(a_prescale_range, prescale < PrescaleW'(PRESCALE_DIV),
    "prescaler left its range")
  `DECAP_ASSERT_ALWAYS(a_stall_blocks_input, in_valid && !advance |-> !s_axis_tready,
    "input taken while input register is held")

endmodule

`default_nettype wire

// ===== tb/decap_period_checker.sv =====
// Result checker for the dual encoder period capture block.
// Watches the cfg, input and result channels, predicts each result beat and
// compares it field by field. Depends on decap_pkg.

module decap_period_checker
  import decap_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CountW-1:0]   cfg_data,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  errors,
  output int                  pending,
  output int                  beats_in,
  output int                  beats_out,
  output int                  captures,
  output int                  timeouts
);

  // Predicted block state
  logic [CountW-1:0]    limit;
  logic                 level_a, level_b;
  logic [CountW-1:0]    count_a, count_b;
  logic [PrescaleW-1:0] presc;
  logic [StampW-1:0]    now_a, prev_a, now_b, prev_b;
  logic [CountW-1:0]    held_a, held_b;

  out_item_t expected_results[$];

  // One tick step: both wheel counters and the prescaler advance.
  function automatic void tick_step(inout out_item_t r);
    count_a = count_a + 16'd1;
    count_b = count_b + 16'd1;
    presc   = presc + 2'd1;
    if (count_a > limit) begin
      r.timeout_a = 1'b1;
      count_a = '0;
    end
    if (count_b > limit) begin
      r.timeout_b = 1'b1;
      count_b = '0;
    end
    r.tick_flag = 1'b1;
    if (presc >= PrescaleDiv) begin
      presc = '0;
      r.half_rate_tick = 1'b1;
    end
  endfunction

  function automatic out_item_t predict_period(opcode_t op, in_item_t it);
    out_item_t r;
    logic      tick_owed;
    r = '0;
    tick_owed = it.tick_pending;
    if (op == OP_TICK) begin
      tick_step(r);
    end else begin
      if (it.enc_a != level_a) begin
        level_a = it.enc_a;
        if (it.enc_a) begin
          prev_a = now_a;
          now_a  = it.timer_value;
          // a pending tick runs once, ahead of the first latch
          if (tick_owed) begin
            tick_step(r);
            tick_owed = 1'b0;
          end
          held_a = count_a;
          count_a = '0;
          r.capture_a = 1'b1;
        end
      end
      if (it.enc_b != level_b) begin
        level_b = it.enc_b;
        if (it.enc_b) begin
          prev_b = now_b;
          now_b  = it.timer_value;
          if (tick_owed) begin
            tick_step(r);
            tick_owed = 1'b0;
          end
          held_b = count_b;
          count_b = '0;
          r.capture_b = 1'b1;
        end
      end
    end
    r.stamp_now_a     = now_a;
    r.stamp_prev_a    = prev_a;
    r.ticks_between_a = held_a;
    r.stamp_now_b     = now_b;
    r.stamp_prev_b    = prev_b;
    r.ticks_between_b = held_b;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (got !== want) begin
      $display("%0t: result beat %0d, %s expected %0d, actual %0d",
               $time, beats_out, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t got, want, pred;
    if (rst) begin
      limit   = LimitReset;
      level_a = 1'b0;
      level_b = 1'b0;
      count_a = '0;
      count_b = '0;
      presc   = '0;
      now_a   = '0;
      prev_a  = '0;
      now_b   = '0;
      prev_b  = '0;
      held_a  = '0;
      held_b  = '0;
      expected_results.delete();
      errors    = 0;
      beats_in  = 0;
      beats_out = 0;
      captures  = 0;
      timeouts  = 0;
    end else begin
      if (cfg_valid && cfg_ready) limit = cfg_data;
      // compare first: a result never leaves in the cycle its input arrives
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        got = out_item_t'(m_axis_tdata[OutItemW-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result beat %0d arrived with nothing expected, actual %h",
                   $time, beats_out, m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("tick_flag", CountW'(want.tick_flag), CountW'(got.tick_flag));
          check_field("timeout_a", CountW'(want.timeout_a), CountW'(got.timeout_a));
          check_field("timeout_b", CountW'(want.timeout_b), CountW'(got.timeout_b));
          check_field("half_rate_tick", CountW'(want.half_rate_tick),
                      CountW'(got.half_rate_tick));
          check_field("capture_a", CountW'(want.capture_a), CountW'(got.capture_a));
          check_field("capture_b", CountW'(want.capture_b), CountW'(got.capture_b));
          check_field("stamp_now_a", CountW'(want.stamp_now_a),
                      CountW'(got.stamp_now_a));
          check_field("stamp_prev_a", CountW'(want.stamp_prev_a),
                      CountW'(got.stamp_prev_a));
          check_field("ticks_between_a", want.ticks_between_a, got.ticks_between_a);
          check_field("stamp_now_b", CountW'(want.stamp_now_b),
                      CountW'(got.stamp_now_b));
          check_field("stamp_prev_b", CountW'(want.stamp_prev_b),
                      CountW'(got.stamp_prev_b));
          check_field("ticks_between_b", want.ticks_between_b, got.ticks_between_b);
          check_field("padding", '0, CountW'(m_axis_tdata[OutDataW-1:OutItemW]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
        pred = predict_period(opcode_t'(s_axis_tuser),
                              in_item_t'(s_axis_tdata[InItemW-1:0]));
        captures += pred.capture_a + pred.capture_b;
        timeouts += pred.timeout_a + pred.timeout_b;
        expected_results.push_back(pred);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_dual_encoder_period_capture.sv =====
// Top of the dual encoder period capture testbench: clock, reset, stimulus,
// limit writes and verdict. Depends on decap_pkg, the block and
// decap_period_checker.

module tb_dual_encoder_period_capture;
  import decap_pkg::*;

  // ~1.05k beats, each at its worst-case idle gap and receiver stall, taken 4x over
  localparam int unsigned CycleLimit = 60_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CountW-1:0]   cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int errors, pending, beats_in, beats_out, captures, timeouts;

  int     cycles = 0;
  int     burst_left = 0;
  int     rx_left = 0;
  int     limit_writes = 0;
  logic   wheel_a = 1'b0;
  logic   wheel_b = 1'b0;

  dual_encoder_period_capture dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  decap_period_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding",
               $time, cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: short stalls between ready runs, now and then a long free run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        rx_left = $urandom_range(1, 4);
      end else begin
        m_axis_tready <= 1'b1;
        rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 6);
      end
    end
    rx_left--;
  end

  // Send one input beat; open a new burst after a random gap when one runs out.
  task automatic send_beat(input opcode_t op, input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(it);
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic sample_pins(input logic a, input logic b,
                             input logic [StampW-1:0] tv, input logic tick_owed);
    in_item_t it;
    it.enc_a        = a;
    it.enc_b        = b;
    it.timer_value  = tv;
    it.tick_pending = tick_owed;
    wheel_a = a;
    wheel_b = b;
    send_beat(OP_PINS, it);
  endtask

  // Tick beats carry random pin fields, which the block must ignore.
  task automatic ticks(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = in_item_t'(InItemW'($urandom_range(0, (1 << InItemW) - 1)));
      send_beat(OP_TICK, it);
    end
  endtask

  // Drop valid and wait for every predicted result to drain.
  task automatic finish_phase();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CountW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // Mostly plausible encoder traffic, with some fully random noise beats.
  task automatic run_random(input int count, input int tick_pct, input int toggle_pct);
    in_item_t it;
    opcode_t  op;
    for (int i = 0; i < count; i++) begin
      it.timer_value  = StampW'($urandom_range(0, 255));
      it.tick_pending = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          op = OP_TICK;
        end else begin
          op = OP_PINS;
          if ($urandom_range(0, 99) < toggle_pct) wheel_a = !wheel_a;
          if ($urandom_range(0, 99) < toggle_pct) wheel_b = !wheel_b;
        end
        it.enc_a = wheel_a;
        it.enc_b = wheel_b;
      end else begin
        op = opcode_t'(1'($urandom_range(0, 1)));
        it.enc_a = 1'($urandom_range(0, 1));
        it.enc_b = 1'($urandom_range(0, 1));
        if (op == OP_PINS) begin
          wheel_a = it.enc_a;
          wheel_b = it.enc_b;
        end
      end
      send_beat(op, it);
    end
  endtask

  task automatic limit_phase(input logic [CountW-1:0] value, input int count,
                             input int tick_pct, input int toggle_pct);
    write_limit(value);
    run_random(count, tick_pct, toggle_pct);
    finish_phase();
  endtask

  // Short tick run under a limit near the top of the range, then a joint rise and random traffic.
  task automatic soak_phase(input logic [CountW-1:0] value, input int n_ticks);
    write_limit(value);
    ticks(n_ticks);
    sample_pins(1'b0, 1'b0, 8'h00, 1'b0);
    sample_pins(1'b1, 1'b1, StampW'($urandom_range(0, 255)), 1'b1);
    run_random(60, 50, 10);
    finish_phase();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);

    // Reset limit: tick with every ignored field high, then edge cases on the pins
    send_beat(OP_TICK, in_item_t'({InItemW{1'b1}}));
    ticks(1);
    sample_pins(1'b1, 1'b0, 8'h00, 1'b0);
    sample_pins(1'b1, 1'b0, 8'hFF, 1'b1);  // level held: pending tick ignored
    sample_pins(1'b0, 1'b0, 8'h5A, 1'b1);  // falling edge only
    sample_pins(1'b1, 1'b1, 8'hFF, 1'b1);  // both rise, one tick
    sample_pins(1'b1, 1'b1, 8'h33, 1'b1);
    sample_pins(1'b0, 1'b0, 8'h00, 1'b0);
    sample_pins(1'b1, 1'b1, 8'h00, 1'b0);
    sample_pins(1'b0, 1'b1, 8'hA5, 1'b1);
    sample_pins(1'b1, 1'b0, 8'h81, 1'b1);
    sample_pins(1'b0, 1'b1, 8'h7E, 1'b0);
    ticks(3);
    finish_phase();

    // Zero limit: every tick times out both wheels
    write_limit('0);
    ticks(2);
    sample_pins(1'b0, 1'b0, 8'h0F, 1'b0);
    sample_pins(1'b1, 1'b1, 8'hC3, 1'b1);
    sample_pins(1'b0, 1'b0, 8'h00, 1'b1);
    run_random(150, 40, 30);
    finish_phase();

    limit_phase(16'd1, 150, 50, 20);
    limit_phase(16'd3, 150, 50, 10);
    limit_phase(CountW'($urandom_range(2, 40)), 200, 60, 5);
    limit_phase(LimitReset, 150, 50, 5);
    soak_phase(16'hFFFE, 10);
    soak_phase(16'hFFFF, 10);
    limit_phase(CountW'($urandom_range(0, 65535)), 90, 50, 20);

    $display("Covered %0d input beats and %0d result beats across %0d limit writes.",
             beats_in, beats_out, limit_writes);
    $display("Predicted %0d wheel captures and %0d counter timeouts, top limits included.",
             captures, timeouts);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/decap_pkg.sv
design/dual_encoder_period_capture.sv
tb/decap_period_checker.sv
tb/tb_dual_encoder_period_capture.sv
